[sv/dll_pkg.sv]
// shared types and constants for the doubly linked list with cursor
// no dependencies
package dll_pkg;

    localparam int POOL_DEPTH = 16;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
    localparam int VALUE_W    = 32;

    typedef enum logic [3:0] {
        OP_CLEAR      = 4'd0,
        OP_INS_FRONT  = 4'd1,
        OP_INS_BACK   = 4'd2,
        OP_TO_FIRST   = 4'd3,
        OP_TO_LAST    = 4'd4,
        OP_DEL_FRONT  = 4'd5,
        OP_DEL_BACK   = 4'd6,
        OP_DEL_AFTER  = 4'd7,
        OP_DEL_BEFORE = 4'd8,
        OP_INS_AFTER  = 4'd9,
        OP_INS_BEFORE = 4'd10,
        OP_UPDATE     = 4'd11,
        OP_NEXT       = 4'd12,
        OP_PREV       = 4'd13
    } t_op;

    // whole list state: pool links and values plus control indexes
    typedef struct packed {
        logic [POOL_DEPTH-1:0][VALUE_W-1:0] value;
        logic [POOL_DEPTH-1:0][IDX_W-1:0]   next;
        logic [POOL_DEPTH-1:0][IDX_W-1:0]   prev;
        logic [IDX_W-1:0]                   head;
        logic [IDX_W-1:0]                   tail;
        logic [IDX_W-1:0]                   cursor;
        logic                               cur_valid;
        logic [IDX_W-1:0]                   free_head;
        logic [CNT_W-1:0]                   free_size;
        logic [CNT_W-1:0]                   fresh;
        logic [CNT_W-1:0]                   size;
    } t_state;

    typedef struct packed {
        logic               pool_full_error;
        logic               list_nonempty;
        logic               cursor_active;
        logic [VALUE_W-1:0] first_value;
        logic [VALUE_W-1:0] last_value;
        logic [VALUE_W-1:0] cursor_value;
        logic [CNT_W-1:0]   node_count;
    } t_result;

endpackage

[sv/dll_step.sv]
// next-state and result logic for one list transaction
// depends on dll_pkg
module dll_step import dll_pkg::*; (
    input  t_state              i_state,
    input  logic [3:0]          i_op,
    input  logic [VALUE_W-1:0]  i_value,
    output t_state              o_state,
    output t_result             o_result
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(POOL_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    always_comb begin
        t_state           s;
        logic             err;
        logic             avail;
        logic [IDX_W-1:0] n;
        logic [IDX_W-1:0] v;
        logic [IDX_W-1:0] w;
        s     = i_state;
        err   = 1'b0;
        avail = (s.free_size != '0) || (s.fresh < DEPTH_C);
        n     = '0;
        v     = '0;
        w     = '0;
        case (t_op'(i_op))
            OP_CLEAR: begin
                s.size      = '0;
                s.free_size = '0;
                s.fresh     = '0;
                s.cur_valid = 1'b0;
            end
            OP_INS_FRONT, OP_INS_BACK: begin
                if (!avail) begin
                    err = 1'b1;
                end else begin
                    // recycled node first, else a fresh slot
                    if (s.free_size != '0) begin
                        n           = s.free_head;
                        s.free_head = s.next[n];
                        s.free_size = s.free_size - ONE_C;
                    end else begin
                        n       = s.fresh[IDX_W-1:0];
                        s.fresh = s.fresh + ONE_C;
                    end
                    s.value[n] = i_value;
                    if (s.size == '0) begin
                        s.head = n;
                        s.tail = n;
                    end else if (t_op'(i_op) == OP_INS_FRONT) begin
                        s.next[n]      = s.head;
                        s.prev[s.head] = n;
                        s.head         = n;
                    end else begin
                        s.prev[n]      = s.tail;
                        s.next[s.tail] = n;
                        s.tail         = n;
                    end
                    s.size = s.size + ONE_C;
                end
            end
            OP_TO_FIRST, OP_TO_LAST: begin
                s.cur_valid = s.size != '0;
                s.cursor    = (t_op'(i_op) == OP_TO_FIRST) ? s.head : s.tail;
            end
            OP_DEL_FRONT, OP_DEL_BACK: begin
                if (s.size != '0) begin
                    v = (t_op'(i_op) == OP_DEL_FRONT) ? s.head : s.tail;
                    if (s.cur_valid && s.cursor == v) s.cur_valid = 1'b0;
                    if (s.size > ONE_C) begin
                        if (t_op'(i_op) == OP_DEL_FRONT) s.head = s.next[v];
                        else                             s.tail = s.prev[v];
                    end
                    s.next[v]   = s.free_head;
                    s.free_head = v;
                    s.free_size = s.free_size + ONE_C;
                    s.size      = s.size - ONE_C;
                end
            end
            OP_DEL_AFTER: begin
                if (s.cur_valid && s.cursor != s.tail) begin
                    v = s.next[s.cursor];
                    if (v == s.tail) begin
                        s.tail = s.cursor;
                    end else begin
                        w                = s.next[v];
                        s.next[s.cursor] = w;
                        s.prev[w]        = s.cursor;
                    end
                    s.next[v]   = s.free_head;
                    s.free_head = v;
                    s.free_size = s.free_size + ONE_C;
                    if (s.size != '0) s.size = s.size - ONE_C;
                end
            end
            OP_DEL_BEFORE: begin
                if (s.cur_valid && s.cursor != s.head) begin
                    v = s.prev[s.cursor];
                    if (v == s.head) begin
                        s.head = s.cursor;
                    end else begin
                        w                = s.prev[v];
                        s.prev[s.cursor] = w;
                        s.next[w]        = s.cursor;
                    end
                    s.next[v]   = s.free_head;
                    s.free_head = v;
                    s.free_size = s.free_size + ONE_C;
                    if (s.size != '0) s.size = s.size - ONE_C;
                end
            end
            OP_INS_AFTER, OP_INS_BEFORE: begin
                if (!avail) begin
                    err = 1'b1;
                end else if (s.cur_valid) begin
                    if (s.free_size != '0) begin
                        n           = s.free_head;
                        s.free_head = s.next[n];
                        s.free_size = s.free_size - ONE_C;
                    end else begin
                        n       = s.fresh[IDX_W-1:0];
                        s.fresh = s.fresh + ONE_C;
                    end
                    s.value[n] = i_value;
                    v          = s.cursor;
                    if (t_op'(i_op) == OP_INS_AFTER) begin
                        if (v == s.tail) s.tail = n;
                        else             s.prev[s.next[v]] = n;
                        s.next[n] = s.next[v];
                        s.prev[n] = v;
                        s.next[v] = n;
                    end else begin
                        if (v == s.head) s.head = n;
                        else             s.next[s.prev[v]] = n;
                        s.prev[n] = s.prev[v];
                        s.next[n] = v;
                        s.prev[v] = n;
                    end
                    s.size = s.size + ONE_C;
                end
            end
            OP_UPDATE: begin
                if (s.cur_valid) s.value[s.cursor] = i_value;
            end
            OP_NEXT: begin
                if (s.cur_valid) begin
                    if (s.cursor == s.tail) s.cur_valid = 1'b0;
                    else                    s.cursor    = s.next[s.cursor];
                end
            end
            OP_PREV: begin
                if (s.cur_valid) begin
                    if (s.cursor == s.head) s.cur_valid = 1'b0;
                    else                    s.cursor    = s.prev[s.cursor];
                end
            end
            default: begin
            end
        endcase
        o_state                  = s;
        o_result.pool_full_error = err;
        o_result.list_nonempty   = s.size != '0;
        o_result.cursor_active   = s.cur_valid;
        o_result.first_value     = (s.size != '0) ? s.value[s.head] : '0;
        o_result.last_value      = (s.size != '0) ? s.value[s.tail] : '0;
        o_result.cursor_value    = s.cur_valid ? s.value[s.cursor] : '0;
        o_result.node_count      = s.size;
    end

endmodule

[sv/doubly_linked_list_with_cursor.sv]
// top level of the doubly linked list with cursor: registers and handshake
// depends on dll_pkg and dll_step
//
// usage
//   - one transaction is one list operation: drive i_op and i_value and
//     raise start; it is taken at any rising edge where start is high and
//     busy is low. busy is held low, so a new operation may be issued in
//     every cycle (one operation per clock sustained)
//   - the operation is captured in an input register, applied to the list
//     state by one pass of combinational logic in dll_step, and the new
//     state and the result are registered together
//   - each operation gives exactly one result: o_strobe is high for one
//     cycle, driven from the result register, with the flags, the
//     first, last and cursor values and the node count after the operation
//   - the receiver cannot stall; results are never held back or dropped
//   - the pool is 16 nodes in flip-flops; clear touches no node, since
//     free nodes come from a recycle stack plus a never-used slot counter
//   - synchronous active-low reset empties the list, drops the cursor and
//     clears the pipeline; node values and links are not reset
module doubly_linked_list_with_cursor import dll_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         i_op,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_strobe,
    output logic               o_pool_full_error,
    output logic               o_list_nonempty,
    output logic               o_cursor_active,
    output logic [VALUE_W-1:0] o_first_value,
    output logic [VALUE_W-1:0] o_last_value,
    output logic [VALUE_W-1:0] o_cursor_value,
    output logic [CNT_W-1:0]   o_node_count
);

    // input register
    logic               r_in_valid;
    logic [3:0]         r_op;
    logic [VALUE_W-1:0] r_value;

    // list state
    t_state  r_state;
    t_state  n_state;
    t_result n_result;

    // result register
    logic    r_strobe;
    t_result r_result;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op    <= i_op;
            r_value <= i_value;
        end
    end

    dll_step u_step (
        .i_state  (r_state),
        .i_op     (r_op),
        .i_value  (r_value),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // control part of the state is reset, pool contents are not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.head      <= '0;
            r_state.tail      <= '0;
            r_state.cursor    <= '0;
            r_state.cur_valid <= 1'b0;
            r_state.free_head <= '0;
            r_state.free_size <= '0;
            r_state.fresh     <= '0;
            r_state.size      <= '0;
        end else if (r_in_valid) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_in_valid;
        end
    end

    assign o_strobe          = r_strobe;
    assign o_pool_full_error = r_result.pool_full_error;
    assign o_list_nonempty   = r_result.list_nonempty;
    assign o_cursor_active   = r_result.cursor_active;
    assign o_first_value     = r_result.first_value;
    assign o_last_value      = r_result.last_value;
    assign o_cursor_value    = r_result.cursor_value;
    assign o_node_count      = r_result.node_count;

    // every accepted transaction yields a result strobe
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##2 o_strobe)
        else $error("result strobe missing");

    // list can never exceed the pool
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_node_count <= CNT_W'(POOL_DEPTH)))
        else $error("node count above pool depth");

    // nonempty flag agrees with the count
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_list_nonempty == (o_node_count != '0)))
        else $error("nonempty flag disagrees with count");

    // empty list reports zero first and last values
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_list_nonempty) |-> (o_first_value == '0 && o_last_value == '0))
        else $error("empty list reports nonzero value");

endmodule

[tb/tb.sv]
// self-checking testbench for doubly_linked_list_with_cursor
// depends on dll_pkg and the rtl top level; carries its own list predictor
module tb;
    import dll_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int N_RANDOM    = 1650;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [3:0]         i_op;
    logic [VALUE_W-1:0] i_value;
    logic               o_strobe;
    logic               o_pool_full_error;
    logic               o_list_nonempty;
    logic               o_cursor_active;
    logic [VALUE_W-1:0] o_first_value;
    logic [VALUE_W-1:0] o_last_value;
    logic [VALUE_W-1:0] o_cursor_value;
    logic [CNT_W-1:0]   o_node_count;

    doubly_linked_list_with_cursor dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_op              (i_op),
        .i_value           (i_value),
        .o_strobe          (o_strobe),
        .o_pool_full_error (o_pool_full_error),
        .o_list_nonempty   (o_list_nonempty),
        .o_cursor_active   (o_cursor_active),
        .o_first_value     (o_first_value),
        .o_last_value      (o_last_value),
        .o_cursor_value    (o_cursor_value),
        .o_node_count      (o_node_count)
    );

    // predictor state: a shadow copy of the node pool and its indexes
    logic [VALUE_W-1:0] pool_val  [POOL_DEPTH];
    logic [IDX_W-1:0]   pool_next [POOL_DEPTH];
    logic [IDX_W-1:0]   pool_prev [POOL_DEPTH];
    logic [IDX_W-1:0]   head_q, tail_q, cur_q, free_top;
    logic               cur_on;
    int                 recycled, fresh_used, length;

    t_result expected_q[$];
    int      mismatches;
    longint  cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("FAIL doubly_linked_list_with_cursor");
                $finish;
            end
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    function automatic void list_reset();
        head_q = '0; tail_q = '0; cur_q = '0; free_top = '0;
        cur_on = 1'b0; recycled = 0; fresh_used = 0; length = 0;
    endfunction

    // hand out a node: recycled stack first, then a never-used slot
    function automatic logic [IDX_W-1:0] grab_node();
        logic [IDX_W-1:0] n;
        if (recycled > 0) begin
            n = free_top;
            free_top = pool_next[n];
            recycled--;
        end else begin
            n = IDX_W'(fresh_used);
            fresh_used++;
        end
        return n;
    endfunction

    function automatic void drop_node(input logic [IDX_W-1:0] n);
        pool_next[n] = free_top;
        free_top = n;
        recycled++;
        if (length > 0) length--;
    endfunction

    // apply one list operation to the shadow state and build its result
    function automatic t_result list_apply(input logic [3:0] op, input logic [VALUE_W-1:0] val);
        t_result r;
        logic [IDX_W-1:0] n, v;
        logic err;
        logic have_free;
        err = 1'b0;
        have_free = (recycled > 0) || (fresh_used < POOL_DEPTH);
        case (op)
            OP_CLEAR: begin
                length = 0; recycled = 0; fresh_used = 0; cur_on = 1'b0;
            end
            OP_INS_FRONT, OP_INS_BACK: begin
                if (!have_free) err = 1'b1;
                else begin
                    n = grab_node();
                    pool_val[n] = val;
                    if (length == 0) begin
                        head_q = n; tail_q = n;
                    end else if (op == OP_INS_FRONT) begin
                        pool_next[n] = head_q; pool_prev[head_q] = n; head_q = n;
                    end else begin
                        pool_prev[n] = tail_q; pool_next[tail_q] = n; tail_q = n;
                    end
                    length++;
                end
            end
            OP_TO_FIRST, OP_TO_LAST: begin
                cur_on = length > 0;
                cur_q = (op == OP_TO_FIRST) ? head_q : tail_q;
            end
            OP_DEL_FRONT, OP_DEL_BACK: begin
                if (length != 0) begin
                    v = (op == OP_DEL_FRONT) ? head_q : tail_q;
                    if (cur_on && cur_q == v) cur_on = 1'b0;
                    if (length > 1) begin
                        if (op == OP_DEL_FRONT) head_q = pool_next[v];
                        else tail_q = pool_prev[v];
                    end
                    drop_node(v);
                end
            end
            OP_DEL_AFTER: begin
                if (cur_on && cur_q != tail_q) begin
                    v = pool_next[cur_q];
                    if (v == tail_q) tail_q = cur_q;
                    else begin
                        pool_next[cur_q] = pool_next[v];
                        pool_prev[pool_next[v]] = cur_q;
                    end
                    drop_node(v);
                end
            end
            OP_DEL_BEFORE: begin
                if (cur_on && cur_q != head_q) begin
                    v = pool_prev[cur_q];
                    if (v == head_q) head_q = cur_q;
                    else begin
                        pool_prev[cur_q] = pool_prev[v];
                        pool_next[pool_prev[v]] = cur_q;
                    end
                    drop_node(v);
                end
            end
            OP_INS_AFTER, OP_INS_BEFORE: begin
                // a full pool is flagged even with the cursor off
                if (!have_free) err = 1'b1;
                else if (cur_on) begin
                    n = grab_node();
                    pool_val[n] = val;
                    v = cur_q;
                    if (op == OP_INS_AFTER) begin
                        if (v == tail_q) tail_q = n;
                        else pool_prev[pool_next[v]] = n;
                        pool_next[n] = pool_next[v];
                        pool_prev[n] = v;
                        pool_next[v] = n;
                    end else begin
                        if (v == head_q) head_q = n;
                        else pool_next[pool_prev[v]] = n;
                        pool_prev[n] = pool_prev[v];
                        pool_next[n] = v;
                        pool_prev[v] = n;
                    end
                    length++;
                end
            end
            OP_UPDATE: if (cur_on) pool_val[cur_q] = val;
            OP_NEXT: if (cur_on) begin
                if (cur_q == tail_q) cur_on = 1'b0;
                else cur_q = pool_next[cur_q];
            end
            OP_PREV: if (cur_on) begin
                if (cur_q == head_q) cur_on = 1'b0;
                else cur_q = pool_prev[cur_q];
            end
            default: ;
        endcase
        r.pool_full_error = err;
        r.list_nonempty   = length > 0;
        r.cursor_active   = cur_on;
        r.first_value     = (length > 0) ? pool_val[head_q] : '0;
        r.last_value      = (length > 0) ? pool_val[tail_q] : '0;
        r.cursor_value    = cur_on ? pool_val[cur_q] : '0;
        r.node_count      = CNT_W'(length);
        return r;
    endfunction

    // result checker: strobe marks a result valid for exactly one cycle
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("result with no transaction pending");
            end else begin
                want = expected_q.pop_front();
                if (o_pool_full_error !== want.pool_full_error)
                    report("pool_full_error", 32'(o_pool_full_error),
                           32'(want.pool_full_error));
                if (o_list_nonempty !== want.list_nonempty)
                    report("list_nonempty", 32'(o_list_nonempty), 32'(want.list_nonempty));
                if (o_cursor_active !== want.cursor_active)
                    report("cursor_active", 32'(o_cursor_active), 32'(want.cursor_active));
                if (o_first_value !== want.first_value)
                    report("first_value", o_first_value, want.first_value);
                if (o_last_value !== want.last_value)
                    report("last_value", o_last_value, want.last_value);
                if (o_cursor_value !== want.cursor_value)
                    report("cursor_value", o_cursor_value, want.cursor_value);
                if (o_node_count !== want.node_count)
                    report("node_count", 32'(o_node_count), 32'(want.node_count));
            end
        end
    end

    // directed table: op, value, and a typed-in check of flags and count where obvious
    typedef struct {
        logic [3:0]         op;
        logic [VALUE_W-1:0] val;
        bit                 typed;
        logic               err;
        logic [CNT_W-1:0]   cnt;
    } t_row;

    t_row rows[$];

    function automatic void add_row(input logic [3:0] op, input logic [VALUE_W-1:0] val,
                                    input bit typed = 0, input logic err = 0,
                                    input int cnt = 0);
        t_row r;
        r.op = op; r.val = val; r.typed = typed; r.err = err; r.cnt = CNT_W'(cnt);
        rows.push_back(r);
    endfunction

    int burst_left;

    // issue one transaction, with bursty gaps; holds start high across a burst
    task automatic send_op(input logic [3:0] op, input logic [VALUE_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end
        start   <= 1'b1;
        i_op    <= op;
        i_value <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_q.push_back(list_apply(op, val));
        burst_left--;
    endtask

    // random op biased toward useful traffic for the current list shape
    function automatic logic [3:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 1) return OP_CLEAR;
        if (r < 2) return 4'($urandom_range(14, 15));
        if (length < 6 && r < 40) return 4'($urandom_range(OP_INS_FRONT, OP_INS_BACK));
        if (r < 22) return 4'($urandom_range(OP_INS_FRONT, OP_INS_BACK));
        if (r < 34) return 4'($urandom_range(OP_INS_AFTER, OP_INS_BEFORE));
        if (r < 44) return 4'($urandom_range(OP_TO_FIRST, OP_TO_LAST));
        if (r < 62) return 4'($urandom_range(OP_NEXT, OP_PREV));
        if (r < 70) return OP_UPDATE;
        return 4'($urandom_range(OP_DEL_FRONT, OP_DEL_BEFORE));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int k;
        t_result got_first;
        mismatches = 0;
        burst_left = 0;
        list_reset();
        for (k = 0; k < POOL_DEPTH; k++) begin
            pool_val[k] = '0; pool_next[k] = '0; pool_prev[k] = '0;
        end
        i_rst_n = 1'b0;
        start = 1'b0;
        i_op = OP_CLEAR;
        i_value = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty-list corners, extremes, every op, then fill the pool to overflow
        add_row(OP_DEL_FRONT, 0, 1, 0, 0);
        add_row(OP_TO_FIRST, 0, 1, 0, 0);
        add_row(OP_INS_AFTER, 5, 1, 0, 0);        // cursor off, nothing consumed
        add_row(OP_INS_BACK, 32'h8000_0000, 1, 0, 1);
        add_row(OP_INS_FRONT, 32'h7fff_ffff, 1, 0, 2);
        add_row(OP_TO_LAST, 0);
        add_row(OP_INS_BEFORE, 32'hffff_ffff);
        add_row(OP_INS_AFTER, 32'h0000_0001);
        add_row(OP_PREV, 0);
        add_row(OP_DEL_AFTER, 0);
        add_row(OP_DEL_BEFORE, 0);
        add_row(OP_UPDATE, 32'h5555_aaaa);
        add_row(OP_NEXT, 0);
        add_row(OP_NEXT, 0);                      // off the tail
        add_row(OP_DEL_BACK, 0);
        add_row(4'd14, 0);
        add_row(4'd15, 32'hffff_ffff);
        add_row(OP_CLEAR, 0, 1, 0, 0);
        foreach (rows[j]) begin
            send_op(rows[j].op, rows[j].val);
            if (rows[j].typed) begin
                got_first = expected_q[$];
                if (got_first.pool_full_error !== rows[j].err ||
                    got_first.node_count !== rows[j].cnt)
                    report("directed row", 32'(j), 32'(rows[j].op));
            end
        end
        for (k = 0; k < POOL_DEPTH + 2; k++) send_op(OP_INS_BACK, pick_value());
        send_op(OP_INS_AFTER, 0);                 // full pool, cursor off
        send_op(OP_CLEAR, 0);

        for (k = 0; k < N_RANDOM; k++) send_op(pick_op(), pick_value());
        start <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) $display("PASS doubly_linked_list_with_cursor");
        else $display("FAIL doubly_linked_list_with_cursor");
        $finish;
    end
endmodule
